// ===== hw/rtl/arc_quadrant_splitter_top_assert.svh =====
// Assertion macros for the arc quadrant splitter checker.
`ifndef ARC_QUADRANT_SPLITTER_TOP_ASSERT_SVH
`define ARC_QUADRANT_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define AQS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define AQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/aqs_pkg.sv =====
// Shared constants and control types of the arc quadrant splitter.
`default_nettype none

package aqs_pkg;

    localparam int ANGLE_FRAC_BITS = 4;
    localparam int ANGLE_W         = 16;
    localparam int WORK_W          = ANGLE_W + 1;
    localparam int QUARTER_TURN    = 90 << ANGLE_FRAC_BITS;
    localparam int FULL_TURN       = 360 << ANGLE_FRAC_BITS;
    localparam int ANGLE_LIMIT     = 1440 << ANGLE_FRAC_BITS;

    // A quarter turn is QUO_DIV shifted left by QUO_SHIFT.
    localparam int QUO_SHIFT   = ANGLE_FRAC_BITS + 1;
    localparam int QUO_DIV     = 45;
    localparam int RECIP_SHIFT = 16;
    localparam int QUO_RECIP   = (1 << RECIP_SHIFT) / QUO_DIV;
    localparam int X_W         = ANGLE_W - QUO_SHIFT;
    localparam int PROD_W      = 2 * X_W;
    localparam int QC_W        = 6;

    typedef struct packed {
        logic load_req;
        logic fix;
        logic load_piece;
    } t_dp_cmd;

    typedef struct packed {
        logic empty_arc;
        logic piece_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/aqs_datapath.sv =====
// Datapath: angle normalization, quadrant search and piece generation.
`default_nettype none

module aqs_datapath
    import aqs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    input  wire logic               i_op,
    input  wire logic [15:0]        i_x_rad,
    input  wire logic [15:0]        i_y_rad,
    input  wire logic [15:0]        i_start_angle,
    input  wire logic [15:0]        i_stop_angle,
    output logic                    o_kind,
    output logic [1:0]              o_quadrant,
    output logic [15:0]             o_x_rad,
    output logic [15:0]             o_y_rad,
    output logic [15:0]             o_seg_start,
    output logic [15:0]             o_seg_stop,
    output logic                    o_last
);

    localparam logic signed [WORK_W-1:0] LIM_POS = WORK_W'(ANGLE_LIMIT);
    localparam logic signed [WORK_W-1:0] LIM_NEG = -WORK_W'(ANGLE_LIMIT);

    function automatic logic signed [WORK_W-1:0] sat_angle(input logic [15:0] v);
        logic signed [WORK_W-1:0] s;
        s = {v[15], v};
        if (s > LIM_POS) begin
            s = LIM_POS;
        end else if (s < LIM_NEG) begin
            s = LIM_NEG;
        end
        return s;
    endfunction

    logic                      r_kind;
    logic [15:0]               r_rx;
    logic [15:0]               r_ry;
    logic [ANGLE_W-1:0]        r_cur;
    logic [ANGLE_W-1:0]        r_end;
    logic                      r_down;
    logic                      r_empty;
    logic [PROD_W-1:0]         r_prod;
    logic [QC_W-1:0]           r_qc;
    logic [WORK_W-1:0]         r_bound;

    logic signed [WORK_W-1:0]  sat_a;
    logic signed [WORK_W-1:0]  sat_b;
    logic signed [WORK_W-1:0]  min_ab;
    logic signed [WORK_W-1:0]  neg_min;
    logic [ANGLE_W-1:0]        nm;
    logic signed [WORK_W-1:0]  offset;
    logic signed [WORK_W-1:0]  a_sh;
    logic signed [WORK_W-1:0]  b_sh;

    logic [QC_W-1:0]           q_est;
    logic [X_W-1:0]            rem;
    logic [X_W-1:0]            rem_fix;
    logic                      rem_over;
    logic [QC_W-1:0]           q_fix;
    logic                      on_bound;
    logic [QC_W-1:0]           qc_init;
    logic [QC_W-1:0]           qc_mult;
    logic [WORK_W-1:0]         bound_init;

    logic [WORK_W-1:0]         end_w;
    logic [WORK_W-1:0]         stop_w;
    logic                      piece_last;

    // Input normalization.
    always_comb begin
        sat_a   = sat_angle(i_start_angle);
        sat_b   = sat_angle(i_stop_angle);
        min_ab  = (sat_a < sat_b) ? sat_a : sat_b;
        neg_min = -min_ab;
        nm      = neg_min[ANGLE_W-1:0];
        if (!min_ab[WORK_W-1]) begin
            offset = '0;
        end else if (nm >= ANGLE_W'(4 * FULL_TURN)) begin
            offset = WORK_W'(5 * FULL_TURN);
        end else if (nm >= ANGLE_W'(3 * FULL_TURN)) begin
            offset = WORK_W'(4 * FULL_TURN);
        end else if (nm >= ANGLE_W'(2 * FULL_TURN)) begin
            offset = WORK_W'(3 * FULL_TURN);
        end else if (nm >= ANGLE_W'(FULL_TURN)) begin
            offset = WORK_W'(2 * FULL_TURN);
        end else begin
            offset = WORK_W'(FULL_TURN);
        end
        a_sh = sat_a + offset;
        b_sh = sat_b + offset;
    end

    // Quotient correction and first boundary.
    always_comb begin
        q_est      = r_prod[RECIP_SHIFT +: QC_W];
        rem        = r_cur[ANGLE_W-1:QUO_SHIFT] - (X_W'(q_est) * X_W'(QUO_DIV));
        rem_over   = (rem >= X_W'(QUO_DIV));
        rem_fix    = rem_over ? (rem - X_W'(QUO_DIV)) : rem;
        q_fix      = rem_over ? (q_est + QC_W'(1)) : q_est;
        on_bound   = (rem_fix == '0) && (r_cur[QUO_SHIFT-1:0] == '0);
        qc_init    = (r_down && on_bound) ? (q_fix - QC_W'(1)) : q_fix;
        qc_mult    = r_down ? qc_init : (qc_init + QC_W'(1));
        bound_init = WORK_W'(qc_mult) * WORK_W'(QUARTER_TURN);
    end

    // Current piece.
    always_comb begin
        end_w = {1'b0, r_end};
        if (r_down) begin
            stop_w = (r_bound < end_w) ? end_w : r_bound;
        end else begin
            stop_w = (r_bound > end_w) ? end_w : r_bound;
        end
        piece_last = (stop_w == end_w);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_cur[ANGLE_W-1:QUO_SHIFT]) * PROD_W'(QUO_RECIP);
        if (i_cmd.load_req) begin
            r_kind  <= i_op;
            r_rx    <= i_x_rad;
            r_ry    <= i_op ? i_y_rad : 16'd0;
            r_cur   <= a_sh[ANGLE_W-1:0];
            r_end   <= b_sh[ANGLE_W-1:0];
            r_down  <= (b_sh < a_sh);
            r_empty <= (a_sh == b_sh);
        end
        if (i_cmd.fix) begin
            r_qc    <= qc_init;
            r_bound <= bound_init;
        end
        if (i_cmd.load_piece) begin
            o_kind      <= r_kind;
            o_quadrant  <= r_qc[1:0];
            o_x_rad     <= r_rx;
            o_y_rad     <= r_ry;
            o_seg_start <= r_cur;
            o_seg_stop  <= stop_w[ANGLE_W-1:0];
            o_last      <= piece_last;
            r_cur       <= stop_w[ANGLE_W-1:0];
            if (r_down) begin
                r_qc    <= r_qc - QC_W'(1);
                r_bound <= r_bound - WORK_W'(QUARTER_TURN);
            end else begin
                r_qc    <= r_qc + QC_W'(1);
                r_bound <= r_bound + WORK_W'(QUARTER_TURN);
            end
        end
    end

    assign o_sts.empty_arc  = r_empty;
    assign o_sts.piece_last = o_last;

endmodule

`default_nettype wire

// ===== hw/rtl/aqs_ctrl.sv =====
// Controller state machine of the arc quadrant splitter.
`default_nettype none

module aqs_ctrl
    import aqs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_STEP,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = i_sts.empty_arc ? S_IDLE : S_FIX;
            end
            S_FIX: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready && i_sts.piece_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_EMIT);
    assign o_cmd.load_req   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.fix        = (r_state == S_FIX);
    assign o_cmd.load_piece = (r_state == S_STEP)
                           || ((r_state == S_EMIT) && i_out_ready && !i_sts.piece_last);

endmodule

`default_nettype wire

// ===== hw/rtl/arc_quadrant_splitter_top.sv =====
// Top level of the arc quadrant splitter.
`default_nettype none

// Cuts one arc request into pieces that each lie within a single 90 degree
// quadrant and sends them out one word per piece, the final piece marked by
// tlast. Angles in sixteenths of a degree are clamped to plus or minus 1440
// degrees and raised by whole turns when either is negative. After a request
// is accepted the block finds the starting quadrant by a reciprocal multiply,
// a one-step quotient correction and the load of the first piece, then emits
// one piece per cycle while m_axis_tready is high. The next request is
// accepted only once the last piece has been taken. A request with equal
// angles yields no word and returns the block to idle for the next request.
module arc_quadrant_splitter_top
    import aqs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x radius, y radius, start angle, stop angle
    input  wire logic [63:0] s_axis_tdata,
    // op
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // quadrant, x radius, y radius, piece start, piece stop, zero fill
    output logic [71:0]      m_axis_tdata,
    // kind
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [1:0]  quadrant;
    logic [15:0] out_rx;
    logic [15:0] out_ry;
    logic [15:0] seg_start;
    logic [15:0] seg_stop;

    aqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    aqs_datapath u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (s_axis_tuser),
        .i_x_rad       (s_axis_tdata[15:0]),
        .i_y_rad       (s_axis_tdata[31:16]),
        .i_start_angle (s_axis_tdata[47:32]),
        .i_stop_angle  (s_axis_tdata[63:48]),
        .o_kind        (m_axis_tuser),
        .o_quadrant    (quadrant),
        .o_x_rad       (out_rx),
        .o_y_rad       (out_ry),
        .o_seg_start   (seg_start),
        .o_seg_stop    (seg_stop),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, seg_stop, seg_start, out_ry, out_rx, quadrant};

endmodule

`default_nettype wire

// ===== hw/rtl/aqs_checker.sv =====
// Port-level checker for the arc quadrant splitter and its bind.
`default_nettype none

`include "arc_quadrant_splitter_top_assert.svh"

module aqs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    `AQS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled word changed")
    `AQS_ASSERT_NOW(a_one_arc, m_axis_tvalid, !s_axis_tready, "request taken while an arc is in flight")
    `AQS_ASSERT_NOW(a_nonempty, m_axis_tvalid, m_axis_tdata[49:34] != m_axis_tdata[65:50], "empty piece emitted")
    `AQS_ASSERT_NEXT(a_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside an arc")
    `AQS_ASSERT_NEXT(a_contig, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tdata[49:34] == $past(m_axis_tdata[65:50]), "pieces not contiguous")

endmodule

bind arc_quadrant_splitter_top aqs_checker u_aqs_checker (.*);

`default_nettype wire

// ===== bench/arc_quadrant_splitter_checker.sv =====
// Checker for the arc quadrant splitter: predicts the quadrant pieces of each request and compares.
`default_nettype none

module arc_quadrant_splitter_checker
    import aqs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // x radius, y radius, start angle, stop angle
    input  wire logic [63:0] i_s_tdata,
    // op
    input  wire logic        i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // quadrant, x radius, y radius, piece start, piece stop, zero fill
    input  wire logic [71:0] i_m_tdata,
    // kind
    input  wire logic        i_m_tuser,
    input  wire logic        i_m_tlast,
    output int               o_errors,
    output int               o_pending,
    output int               o_pieces
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [1:0]  quadrant;
        logic [15:0] x_rad;
        logic [15:0] y_rad;
        logic [15:0] seg_start;
        logic [15:0] seg_stop;
        logic        last;
    } t_piece;

    t_piece expected_pieces[$];
    int     error_count = 0;
    int     piece_count = 0;

    assign o_errors  = error_count;
    assign o_pending = expected_pieces.size();
    assign o_pieces  = piece_count;

    function automatic int clamp_angle(input logic [15:0] raw);
        int v;
        v = $signed(raw);
        if (v > ANGLE_LIMIT) begin
            v = ANGLE_LIMIT;
        end else if (v < -ANGLE_LIMIT) begin
            v = -ANGLE_LIMIT;
        end
        return v;
    endfunction

    // Walks the arc from start toward stop and queues one piece per quadrant crossed.
    task automatic split_arc(input logic op, input logic [63:0] word);
        int     from_angle;
        int     to_angle;
        int     lowest;
        int     turns;
        int     cur;
        int     nxt;
        int     qc;
        logic   down;
        logic   more;
        t_piece p;
        from_angle = clamp_angle(word[47:32]);
        to_angle   = clamp_angle(word[63:48]);
        if (from_angle < 0 || to_angle < 0) begin
            lowest     = (from_angle < to_angle) ? from_angle : to_angle;
            turns      = (-lowest) / FULL_TURN + 1;
            from_angle = from_angle + turns * FULL_TURN;
            to_angle   = to_angle + turns * FULL_TURN;
        end
        cur  = from_angle;
        down = to_angle < cur;
        more = cur != to_angle;
        while (more) begin
            qc = cur / QUARTER_TURN;
            if (!down) begin
                nxt = (qc + 1) * QUARTER_TURN;
                if (nxt > to_angle) begin
                    nxt = to_angle;
                end
            end else begin
                if (qc * QUARTER_TURN == cur) begin
                    qc = qc - 1;
                end
                nxt = qc * QUARTER_TURN;
                if (nxt < to_angle) begin
                    nxt = to_angle;
                end
            end
            more        = nxt != to_angle;
            p.kind      = op;
            p.quadrant  = qc[1:0];
            p.x_rad     = word[15:0];
            p.y_rad     = op ? word[31:16] : 16'd0;
            p.seg_start = cur[15:0];
            p.seg_stop  = nxt[15:0];
            p.last      = !more;
            expected_pieces.push_back(p);
            cur = nxt;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_piece got;
        t_piece want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                split_arc(i_s_tuser, i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.kind      = i_m_tuser;
                got.quadrant  = i_m_tdata[1:0];
                got.x_rad     = i_m_tdata[17:2];
                got.y_rad     = i_m_tdata[33:18];
                got.seg_start = i_m_tdata[49:34];
                got.seg_stop  = i_m_tdata[65:50];
                got.last      = i_m_tlast;
                if (expected_pieces.size() == 0) begin
                    $display("%0t ns: unexpected word, expected none, got %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_pieces.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("quadrant", want.quadrant, got.quadrant);
                    check_field("x radius", want.x_rad, got.x_rad);
                    check_field("y radius", want.y_rad, got.y_rad);
                    check_field("seg_start", want.seg_start, got.seg_start);
                    check_field("seg_stop", want.seg_stop, got.seg_stop);
                    check_field("last", want.last, got.last);
                    piece_count++;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/arc_quadrant_splitter_top_tb.sv =====
// Testbench top for the arc quadrant splitter: clock, reset, stimulus, stalls and verdict.
`default_nettype none

module arc_quadrant_splitter_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ARCS = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 12;
    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int error_total;
    int pending_pieces;
    int pieces_checked;
    int arcs_sent = 0;
    int quiet_cycles = 0;
    bit hold_request = 1'b0;
    bit steady = 1'b0;

    arc_quadrant_splitter_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    arc_quadrant_splitter_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_m_tlast  (m_axis_tlast),
        .o_errors   (error_total),
        .o_pending  (pending_pieces),
        .o_pieces   (pieces_checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [63:0] arc_word(input logic [15:0] rx, input logic [15:0] ry,
                                             input int from_angle, input int to_angle);
        return {to_angle[15:0], from_angle[15:0], ry, rx};
    endfunction

    task automatic send_arc(input logic op, input logic [63:0] word);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        arcs_sent++;
    endtask

    task automatic random_arc(output logic op, output logic [63:0] word);
        int          pick;
        int          from_angle;
        int          to_angle;
        logic [15:0] rx;
        logic [15:0] ry;
        pick = $urandom_range(0, 9);
        rx   = 16'($urandom);
        ry   = 16'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            rx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            ry = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        case (pick)
            0: begin
                from_angle = $urandom_range(0, 65535);
                to_angle   = $urandom_range(0, 65535);
            end
            1: begin
                from_angle = $urandom_range(0, 46080) - 23040;
                to_angle   = from_angle;
            end
            2, 3, 4, 5, 6: begin
                from_angle = $urandom_range(0, 11520) - 5760;
                to_angle   = from_angle + $urandom_range(0, 11520) - 5760;
            end
            7, 8: begin
                from_angle = $urandom_range(0, 23040) - 11520;
                to_angle   = $urandom_range(0, 23040) - 11520;
            end
            default: begin
                from_angle = $urandom_range(0, 46080) - 23040;
                to_angle   = $urandom_range(0, 46080) - 23040;
            end
        endcase
        if (pick != 0 && $urandom_range(0, 3) == 0) begin
            from_angle = (from_angle / 1440) * 1440;
        end
        if (pick > 1 && $urandom_range(0, 3) == 0) begin
            to_angle = (to_angle / 1440) * 1440;
        end
        op   = 1'($urandom_range(0, 1));
        word = arc_word(rx, ry, from_angle, to_angle);
    endtask

    // Receiver: random stalls, one long hold-off on request, none during the steady phase.
    initial begin : drain
        int gap;
        forever begin
            if (hold_request) begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                gap = steady ? 0 : $urandom_range(0, 9);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin : stimulus
        logic        op;
        logic [63:0] word;
        do @(posedge i_clk); while (!i_rst_n);

        // Directed corner cases.
        send_arc(1'b0, arc_word(16'd100, 16'hFFFF, 0, 1440));
        send_arc(1'b1, arc_word(16'hFFFF, 16'hFFFF, 100, 3000));
        send_arc(1'b1, arc_word(16'h0000, 16'h0000, 3000, 100));
        send_arc(1'b0, arc_word(16'h1234, 16'h5678, 1440, 2000));
        send_arc(1'b1, arc_word(16'h1234, 16'h5678, 2880, 2000));
        send_arc(1'b1, arc_word(16'd7, 16'd9, 500, 500));
        send_arc(1'b0, arc_word(16'd7, 16'd9, -500, -500));
        send_arc(1'b1, arc_word(16'hA5A5, 16'h5A5A, -100, 200));
        send_arc(1'b0, arc_word(16'hFFFF, 16'hFFFF, -23040, 23040));
        send_arc(1'b1, arc_word(16'hFFFF, 16'h0001, 23040, -23040));
        send_arc(1'b1, arc_word(16'd1, 16'd2, 32767, -32768));
        send_arc(1'b0, arc_word(16'd3, 16'd4, -32768, 0));
        send_arc(1'b1, arc_word(16'd5, 16'd6, 30000, 25000));
        send_arc(1'b0, arc_word(16'd8, 16'd8, 0, 5760));
        send_arc(1'b1, arc_word(16'd8, 16'd8, 5760, 0));
        send_arc(1'b1, arc_word(16'd11, 16'd12, -1, 0));
        send_arc(1'b0, arc_word(16'd13, 16'd14, 1, 2));
        send_arc(1'b1, arc_word(16'd15, 16'd16, -5760, -1440));
        send_arc(1'b0, arc_word(16'd17, 16'd18, 23040, 23039));
        send_arc(1'b1, arc_word(16'd19, 16'd20, -23040, -23039));

        for (int n = 0; n < RANDOM_ARCS; n++) begin
            if (n == 150) begin
                hold_request = 1'b1;
            end
            if (n == 300) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending_pieces != 0);
            end
            steady = (n >= 380 && n < 440);
            random_arc(op, word);
            send_arc(op, word);
        end
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_pieces != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d arc requests and checked %0d quadrant pieces.",
                 arcs_sent, pieces_checked);
        $display("Included saturated, negative, zero-length and full-range arcs under stalls.");
        if (error_total == 0 && pending_pieces == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/aqs_pkg.sv
hw/rtl/aqs_datapath.sv
hw/rtl/aqs_ctrl.sv
hw/rtl/arc_quadrant_splitter_top.sv
hw/rtl/aqs_checker.sv
bench/arc_quadrant_splitter_checker.sv
bench/arc_quadrant_splitter_top_tb.sv
